/* rtl/arpc_pkg.sv */
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [10:0] HEADER_BYTES = 11'd28;
  localparam logic [15:0] HW_ETHERNET  = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] OP_REQUEST   = 16'h0001;
  localparam logic [15:0] OP_REPLY     = 16'h0002;

  localparam logic FUNC_LEARN  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_KNOWN    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_SHORT    = 3'd3,
    STAT_BADTYPE  = 3'd4,
    STAT_OTHEROP  = 3'd5,
    STAT_HIT      = 3'd6,
    STAT_MISS     = 3'd7
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input item and restart the scan
    logic scan;       // issue the next table read, compare the previous one
    logic scan_done;  // capture the search outcome
    logic finish;     // commit the item and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic chk_fail;
    logic match;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

/* rtl/arpc_ctrl.sv */
module arpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  arpc_pkg::sts_t  sts_i,
  output arpc_pkg::cmd_t  cmd_o
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.chk_fail || sts_i.match || sts_i.scan_end) begin
          cmd_o.scan_done = 1'b1;
          state_d         = S_RESULT;
        end
      end
      S_RESULT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/arpc_dp.sv */
module arpc_dp #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arpc_pkg::cmd_t  cmd_i,
  output arpc_pkg::sts_t  sts_o,
  input  logic            func_i,
  input  logic [10:0]     packet_length_i,
  input  logic [15:0]     hw_type_i,
  input  logic [15:0]     proto_type_i,
  input  logic [15:0]     opcode_i,
  input  logic [31:0]     ip_address_i,
  input  logic [47:0]     sender_mac_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [47:0]     mac_address_o,
  output logic [4:0]      entry_count_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  logic [31:0] ip_mem  [TABLE_ENTRIES];
  logic [47:0] mac_mem [TABLE_ENTRIES];

  logic             func_q;
  logic [31:0]      ip_q;
  logic [47:0]      mac_in_q;
  logic             chk_fail_q, chk_fail_d;
  status_e          chk_code_q, chk_code_d;
  logic [CNT_W-1:0] rd_idx_q;
  logic             pend_q;
  logic [31:0]      ip_rd_q;
  logic [47:0]      mac_rd_q;
  logic             found_q;
  logic [47:0]      hit_mac_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [47:0]      out_mac_q;
  logic [4:0]       out_cnt_q;

  logic             issue;
  logic             match;
  logic             wr_en;
  status_e          res_status;
  logic [47:0]      res_mac;
  logic [CNT_W+4:0] fill_ext;

  // Header checks on learn items, in priority order: length, types, opcode
  always_comb begin
    chk_fail_d = 1'b0;
    chk_code_d = STAT_MISS;
    if (func_i == FUNC_LEARN) begin
      if (packet_length_i < HEADER_BYTES) begin
        chk_fail_d = 1'b1;
        chk_code_d = STAT_SHORT;
      end else if (hw_type_i != HW_ETHERNET || proto_type_i != PROTO_IPV4) begin
        chk_fail_d = 1'b1;
        chk_code_d = STAT_BADTYPE;
      end else if (opcode_i != OP_REQUEST && opcode_i != OP_REPLY) begin
        chk_fail_d = 1'b1;
        chk_code_d = STAT_OTHEROP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_i;
      ip_q       <= ip_address_i;
      mac_in_q   <= sender_mac_i;
      chk_code_q <= chk_code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_fail_q <= 1'b0;
    end else if (cmd_i.load) begin
      chk_fail_q <= chk_fail_d;
    end
  end

  // Scan: one read issued per cycle, compared in the cycle after
  assign issue = rd_idx_q < fill_q;
  assign match = pend_q && (ip_rd_q == ip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.load) begin
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.scan) begin
      pend_q <= issue;
      if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && issue) begin
      ip_rd_q  <= ip_mem[rd_idx_q[IDX_W-1:0]];
      mac_rd_q <= mac_mem[rd_idx_q[IDX_W-1:0]];
    end
    if (wr_en) begin
      ip_mem[fill_q[IDX_W-1:0]]  <= ip_q;
      mac_mem[fill_q[IDX_W-1:0]] <= mac_in_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_done) begin
      found_q <= match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_done) begin
      hit_mac_q <= mac_rd_q;
    end
  end

  always_comb begin
    res_status = STAT_MISS;
    res_mac    = '0;
    wr_en      = 1'b0;
    if (chk_fail_q) begin
      res_status = chk_code_q;
    end else if (func_q == FUNC_LOOKUP) begin
      if (found_q) begin
        res_status = STAT_HIT;
        res_mac    = hit_mac_q;
      end
    end else if (found_q) begin
      res_status = STAT_KNOWN;
    end else if (fill_q == FULL_CNT) begin
      res_status = STAT_FULL;
    end else begin
      res_status = STAT_INSERTED;
      wr_en      = cmd_i.finish;
    end
  end

  assign fill_d   = fill_q + CNT_W'(wr_en);
  assign fill_ext = {5'd0, fill_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Output register: a finished result waits here until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_mac_q    <= res_mac;
      out_cnt_q    <= fill_ext[4:0];
    end
  end

  assign sts_o.chk_fail = chk_fail_q;
  assign sts_o.match    = match;
  assign sts_o.scan_end = !issue && !pend_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign mac_address_o = out_mac_q;
  assign entry_count_o = out_cnt_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count above table size");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> fill_q == $past(fill_q) + 1'b1)
    else $error("append did not advance fill count");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished item not presented");

endmodule

/* rtl/arp_address_cache_core.sv */
// Append-only IPv4 to MAC cache. func_i = 0 learns the sender of a received
// ARP packet (dropped as short, bad type or other opcode when the header
// checks fail, reported known if the address is present, full if there is no
// room); func_i = 1 looks an address up and returns the first matching MAC.
// One item is handled at a time. Its handling time is set by a linear scan
// that reads one table entry per cycle from the address memories and
// compares it in the cycle after. A scan with no match runs over every filled
// entry, a match ends the scan at the first matching entry, and a failed
// header check ends it at once. The next item is taken in the cycle after
// the result is registered.
// The result sits in an output register, so a new item can be taken while
// the previous result waits. Entries are never replaced or aged, and the
// table starts empty after reset with no clearing pass.
module arp_address_cache_core #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [10:0] packet_length_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [15:0] opcode_i,
  input  logic [31:0] ip_address_i,
  input  logic [47:0] sender_mac_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [47:0] mac_address_o,
  output logic [4:0]  entry_count_o
);
  import arpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .packet_length_i (packet_length_i),
    .hw_type_i       (hw_type_i),
    .proto_type_i    (proto_type_i),
    .opcode_i        (opcode_i),
    .ip_address_i    (ip_address_i),
    .sender_mac_i    (sender_mac_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .mac_address_o   (mac_address_o),
    .entry_count_o   (entry_count_o)
  );

endmodule
